>>> design/cmmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmmc_pkg
// Shared types, codes and reset values of the curtain motor mode controller.
// ----------------------------------------------------------------------------
package cmmc_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int TICK_BITS_DEF  = 16;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 3;

  typedef logic [1:0] drv_t;
  localparam drv_t DRV_STOP  = 2'd0;
  localparam drv_t DRV_OPEN  = 2'd1;
  localparam drv_t DRV_CLOSE = 2'd2;
  localparam drv_t DRV_BAD   = 2'd3;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_AUTO   = 2'd1;
  localparam mode_t MODE_MANUAL = 2'd2;

  typedef logic [1:0] run_code_t;
  localparam run_code_t RUN_IDLE  = 2'd0;
  localparam run_code_t RUN_CLOSE = 2'd1;
  localparam run_code_t RUN_OPEN  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_CLOSE = 3'b010,
    PH_OPEN  = 3'b100
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DARK        = 3'd0,
    CFG_BRIGHT      = 3'd1,
    CFG_CLOSE_TOD   = 3'd2,
    CFG_OPEN_TOD    = 3'd3,
    CFG_LOCKOUT     = 3'd4,
    CFG_OPEN_TICKS  = 3'd5,
    CFG_CLOSED_CODE = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [22:0]        dark_threshold;
    logic [22:0]        bright_threshold;
    logic signed [17:0] close_time_of_day;
    logic signed [17:0] open_time_of_day;
    logic [31:0]        lockout_seconds;
    logic [15:0]        open_run_ticks;
    logic [7:0]         closed_code;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    dark_threshold:    23'd100,
    bright_threshold:  23'd10000,
    close_time_of_day: -18'sd1,
    open_time_of_day:  -18'sd1,
    lockout_seconds:   32'd79200,
    open_run_ticks:    16'd50,
    closed_code:       8'hFF
  };

  typedef struct packed {
    logic [31:0] now_seconds;
    logic [16:0] day_seconds;
    logic [22:0] light_centilux;
    logic [7:0]  position;
    logic [1:0]  direction_request;
    logic [1:0]  run_mode;
  } in_word_t;

  typedef struct packed {
    logic [1:0] motor_command;
    logic       command_changed;
    logic [1:0] run_phase;
  } out_word_t;

  typedef struct packed {
    phase_t phase;
    drv_t   motor;
    drv_t   prev_dir;
    logic   close_seen;
    logic   open_seen;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{
    phase:      PH_IDLE,
    motor:      DRV_STOP,
    prev_dir:   DRV_STOP,
    close_seen: 1'b0,
    open_seen:  1'b0
  };

endpackage

>>> design/curtain_motor_mode_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// curtain_motor_mode_controller_unit
// Curtain motor controller: one tick word in, one motor command word out.
// ----------------------------------------------------------------------------
// Accepts a new tick word every clock unless out_stall backs up the pipe and
// raises in_stall; each yields one result word via the input register, then
// the result register. A tick is decided in one pass of logic between the two
// registers; controller state is updated as the word moves into the result
// register. Configuration is written via cfg_we, cfg_index and cfg_wdata; the
// user must do so only while no word is in flight, unenforced by the block.
module curtain_motor_mode_controller_unit #(
  parameter int TIME_BITS       = cmmc_pkg::TIME_BITS_DEF,
  parameter int TICK_COUNT_BITS = cmmc_pkg::TICK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cmmc_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cmmc_pkg::out_word_t             out_word,
  input  logic                            cfg_we,
  input  logic [cmmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmmc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cmmc_pkg::*;

  cfg_t                       cfg_r;
  in_word_t                   s1_word_r;
  logic                       s1_valid_r;
  logic                       out_valid_r;
  out_word_t                  out_word_r;
  ctrl_t                      ctrl_r;
  ctrl_t                      ctrl_nxt;
  logic [TICK_COUNT_BITS-1:0] tick_r;
  logic [TICK_COUNT_BITS-1:0] tick_nxt;
  logic [TIME_BITS-1:0]       start_r;
  logic [TIME_BITS-1:0]       start_nxt;
  logic [TIME_BITS-1:0]       last_close_r;
  logic [TIME_BITS-1:0]       last_close_nxt;
  logic [TIME_BITS-1:0]       last_open_r;
  logic [TIME_BITS-1:0]       last_open_nxt;
  logic                       changed;
  logic                       out_load;
  logic                       s1_move;
  logic                       in_take;
  run_code_t                  run_code;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  cmmc_step #(
    .TIME_BITS       (TIME_BITS),
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_step (
    .cfg            (cfg_r),
    .item           (s1_word_r),
    .ctrl_cur       (ctrl_r),
    .tick_cur       (tick_r),
    .start_cur      (start_r),
    .last_close_cur (last_close_r),
    .last_open_cur  (last_open_r),
    .ctrl_nxt       (ctrl_nxt),
    .tick_nxt       (tick_nxt),
    .start_nxt      (start_nxt),
    .last_close_nxt (last_close_nxt),
    .last_open_nxt  (last_open_nxt),
    .changed        (changed)
  );

  always_comb begin
    unique case (ctrl_nxt.phase)
      PH_CLOSE: run_code = RUN_CLOSE;
      PH_OPEN:  run_code = RUN_OPEN;
      default:  run_code = RUN_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DARK:        cfg_r.dark_threshold    <= cfg_wdata[22:0];
        CFG_BRIGHT:      cfg_r.bright_threshold  <= cfg_wdata[22:0];
        CFG_CLOSE_TOD:   cfg_r.close_time_of_day <= cfg_wdata[17:0];
        CFG_OPEN_TOD:    cfg_r.open_time_of_day  <= cfg_wdata[17:0];
        CFG_LOCKOUT:     cfg_r.lockout_seconds   <= cfg_wdata[31:0];
        CFG_OPEN_TICKS:  cfg_r.open_run_ticks    <= cfg_wdata[15:0];
        CFG_CLOSED_CODE: cfg_r.closed_code       <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // handshake and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      ctrl_r       <= CTRL_RESET;
      tick_r       <= '0;
      start_r      <= '0;
      last_close_r <= '0;
      last_open_r  <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r  <= 1'b1;
        ctrl_r       <= ctrl_nxt;
        tick_r       <= tick_nxt;
        start_r      <= start_nxt;
        last_close_r <= last_close_nxt;
        last_open_r  <= last_open_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_word;
    end
    if (s1_move) begin
      out_word_r.motor_command   <= ctrl_nxt.motor;
      out_word_r.command_changed <= changed;
      out_word_r.run_phase       <= run_code;
    end
  end

endmodule

>>> design/cmmc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmmc_step
// Next-state decision for one tick word: run tracking, direction requests,
// auto and manual triggers with lockout.
// ----------------------------------------------------------------------------
module cmmc_step #(
  parameter int TIME_BITS       = cmmc_pkg::TIME_BITS_DEF,
  parameter int TICK_COUNT_BITS = cmmc_pkg::TICK_BITS_DEF
) (
  input  cmmc_pkg::cfg_t             cfg,
  input  cmmc_pkg::in_word_t         item,
  input  cmmc_pkg::ctrl_t            ctrl_cur,
  input  logic [TICK_COUNT_BITS-1:0] tick_cur,
  input  logic [TIME_BITS-1:0]       start_cur,
  input  logic [TIME_BITS-1:0]       last_close_cur,
  input  logic [TIME_BITS-1:0]       last_open_cur,
  output cmmc_pkg::ctrl_t            ctrl_nxt,
  output logic [TICK_COUNT_BITS-1:0] tick_nxt,
  output logic [TIME_BITS-1:0]       start_nxt,
  output logic [TIME_BITS-1:0]       last_close_nxt,
  output logic [TIME_BITS-1:0]       last_open_nxt,
  output logic                       changed
);
  import cmmc_pkg::*;

  localparam int CMP_W  = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int TCMP_W = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
  localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

  logic [TIME_BITS-1:0]       now;
  logic [TIME_BITS-1:0]       close_age;
  logic [TIME_BITS-1:0]       open_age;
  logic                       close_lock;
  logic                       open_lock;
  logic [TICK_COUNT_BITS-1:0] tick_inc;
  logic                       open_done;
  logic [17:0]                close_diff;
  logic [17:0]                open_diff;
  logic                       at_close;
  logic                       at_open;
  logic                       want_close;
  logic                       want_open;

  assign now       = TIME_BITS'(item.now_seconds);
  assign close_age = now - last_close_cur;
  assign open_age  = now - last_open_cur;
  assign close_lock = ctrl_cur.close_seen &&
                      (CMP_W'(close_age) < CMP_W'(cfg.lockout_seconds));
  assign open_lock  = ctrl_cur.open_seen &&
                      (CMP_W'(open_age) < CMP_W'(cfg.lockout_seconds));

  assign tick_inc  = (tick_cur != TICK_MAX) ? tick_cur + 1'b1 : tick_cur;
  assign open_done = (TCMP_W'(tick_inc) >= TCMP_W'(cfg.open_run_ticks)) ||
                     (tick_inc == TICK_MAX);

  // time-of-day match: target enabled, day at or up to one second past it
  assign close_diff = {1'b0, item.day_seconds} - cfg.close_time_of_day;
  assign open_diff  = {1'b0, item.day_seconds} - cfg.open_time_of_day;
  assign at_close = !cfg.close_time_of_day[17] &&
                    ({1'b0, item.day_seconds} >= cfg.close_time_of_day) &&
                    (close_diff < 18'd2);
  assign at_open  = !cfg.open_time_of_day[17] &&
                    ({1'b0, item.day_seconds} >= cfg.open_time_of_day) &&
                    (open_diff < 18'd2);

  always_comb begin
    want_close = 1'b0;
    want_open  = 1'b0;
    if (item.run_mode == MODE_AUTO) begin
      want_close = item.light_centilux < cfg.dark_threshold;
      want_open  = !want_close && (item.light_centilux > cfg.bright_threshold);
    end else if (item.run_mode == MODE_MANUAL) begin
      want_close = at_close;
      want_open  = !at_close && at_open;
    end
  end

  always_comb begin
    ctrl_nxt       = ctrl_cur;
    tick_nxt       = tick_cur;
    start_nxt      = start_cur;
    last_close_nxt = last_close_cur;
    last_open_nxt  = last_open_cur;
    changed        = 1'b0;
    unique case (ctrl_cur.phase)
      PH_CLOSE: begin
        if (item.position == cfg.closed_code) begin
          ctrl_nxt.motor      = DRV_STOP;
          ctrl_nxt.phase      = PH_IDLE;
          ctrl_nxt.close_seen = 1'b1;
          last_close_nxt      = start_cur;
          changed             = 1'b1;
        end
      end
      PH_OPEN: begin
        tick_nxt = tick_inc;
        if (open_done) begin
          ctrl_nxt.motor     = DRV_STOP;
          ctrl_nxt.phase     = PH_IDLE;
          ctrl_nxt.open_seen = 1'b1;
          last_open_nxt      = start_cur;
          changed            = 1'b1;
        end
      end
      PH_IDLE: begin
        if (item.direction_request != ctrl_cur.prev_dir) begin
          ctrl_nxt.prev_dir = item.direction_request;
          if (item.direction_request != DRV_BAD) begin
            ctrl_nxt.motor = item.direction_request;
            changed        = 1'b1;
          end
        end else if (want_close) begin
          // a locked close does not fall through to open
          if (!close_lock) begin
            ctrl_nxt.motor = DRV_CLOSE;
            ctrl_nxt.phase = PH_CLOSE;
            start_nxt      = now;
            changed        = 1'b1;
          end
        end else if (want_open && !open_lock) begin
          ctrl_nxt.motor = DRV_OPEN;
          ctrl_nxt.phase = PH_OPEN;
          start_nxt      = now;
          tick_nxt       = '0;
          changed        = 1'b1;
        end
      end
      default: begin
        ctrl_nxt.phase = PH_IDLE;
      end
    endcase
  end

endmodule
